>>> hw/rtl/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Types and constants shared by the tile line clipper and its users.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int IN_W           = 32;
  localparam int TILE_W         = 31;
  localparam int TAG_W          = 31;
  localparam int OUT_W          = 48;
  // clip parameters are unsigned Q1.24; quotients are resolved to 26 bits
  localparam int T_FRAC         = 24;
  localparam int Q_BITS         = 26;

  typedef struct packed {
    logic signed [IN_W-1:0] start_x;
    logic signed [IN_W-1:0] start_y;
    logic signed [IN_W-1:0] end_x;
    logic signed [IN_W-1:0] end_y;
    logic signed [IN_W-1:0] tile_col;
    logic signed [IN_W-1:0] tile_row;
    logic [TAG_W-1:0]       source_tag;
  } item_t;

  typedef struct packed {
    logic                    kept;
    logic signed [OUT_W-1:0] clip_start_x;
    logic signed [OUT_W-1:0] clip_start_y;
    logic signed [OUT_W-1:0] clip_end_x;
    logic signed [OUT_W-1:0] clip_end_y;
    logic [TAG_W-1:0]        tag_out;
  } result_t;

endpackage

>>> hw/rtl/tile_line_clipper.sv
// ----------------------------------------------------------------------------
// tile_line_clipper
// Clips a line segment to one square tile box (Liang-Barsky) in a pipeline.
// ----------------------------------------------------------------------------
// One request is taken in every cycle (busy is never raised) and its result
// appears with result_valid, in request order. The pipeline runs through
// capture, tile multiply, box clamp, edge term and four parallel restoring
// dividers (an overflow check, then one quotient bit per stage), then the
// parameter combine, endpoint multiply, rounding and output stages. The receiver
// cannot stall: every result is shown for one cycle only. tile_size is
// taken on cfg_valid (cfg_ready is always high); write it only while idle.
module tile_line_clipper
  import tlc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  item_t             item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TILE_W-1:0] cfg_data,
  output logic              result_valid,
  output result_t           result
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;
  localparam int BW   = CW + 33;
  localparam int NW   = CW + Q_BITS + 1;
  localparam int PW   = Q_BITS + DW;
  localparam int EW   = CW + FRAC_BITS + 3;
  localparam int SH   = T_FRAC - FRAC_BITS;
  localparam int DV_N = Q_BITS + 1;

  localparam logic signed [BW-1:0] CHI = BW'((longint'(1) <<< (CW - 1)) - 1);
  localparam logic signed [BW-1:0] CLO = -CHI - BW'(1);
  localparam logic [PW-1:0]        HALF = (PW'(1) << SH) >> 1;
  localparam logic [Q_BITS-1:0]    R_SAT = Q_BITS'(2) << T_FRAC;
  localparam logic signed [Q_BITS:0] T_ONE = (Q_BITS + 1)'(1) << T_FRAC;

  typedef struct packed {
    logic signed [CW-1:0] x0;
    logic signed [CW-1:0] y0;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [TAG_W-1:0]     tag;
    logic [3:0]           pneg;
    logic [3:0]           pzero;
    logic [3:0]           rneg;
    logic                 zok;
  } side_t;

  function automatic logic signed [CW-1:0] clamp_c(input logic signed [BW-1:0] v);
    logic signed [BW-1:0] r;
    r = v;
    if (v < CLO) r = CLO;
    if (v > CHI) r = CHI;
    return r[CW-1:0];
  endfunction

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic signed [EW-1:0] place(input logic signed [CW-1:0] a0,
                                                 input logic signed [PW-1:0] prod);
    logic [PW-1:0]        m;
    logic signed [EW-1:0] me;
    logic signed [EW-1:0] off;
    m   = prod[PW-1] ? PW'(-prod) : PW'(prod);
    m   = (m + HALF) >> SH;
    me  = EW'(m);
    off = prod[PW-1] ? -me : me;
    return (EW'(a0) <<< FRAC_BITS) + off;
  endfunction

  logic [TILE_W-1:0] tsize;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tsize <= TILE_W'(1);
    end else if (cfg_valid) begin
      tsize <= cfg_data;
    end
  end

  // capture
  logic                 c_vld;
  logic signed [CW-1:0] c_x0, c_y0, c_x1, c_y1, c_col, c_row;
  logic [TILE_W-1:0]    c_sz;
  logic [TAG_W-1:0]     c_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= start;
    end
    c_x0  <= item.start_x[CW-1:0];
    c_y0  <= item.start_y[CW-1:0];
    c_x1  <= item.end_x[CW-1:0];
    c_y1  <= item.end_y[CW-1:0];
    c_col <= item.tile_col[CW-1:0];
    c_row <= item.tile_row[CW-1:0];
    c_sz  <= (tsize == '0) ? TILE_W'(1) : tsize;
    c_tag <= item.source_tag;
  end

  // tile origin
  logic                    a_vld;
  logic signed [CW+31:0]   a_ox, a_oy;
  logic signed [CW-1:0]    a_x0, a_y0;
  logic signed [DW-1:0]    a_dx, a_dy;
  logic [TILE_W-1:0]       a_sz;
  logic [TAG_W-1:0]        a_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= c_vld;
    end
    a_ox  <= c_col * $signed({1'b0, c_sz});
    a_oy  <= c_row * $signed({1'b0, c_sz});
    a_dx  <= DW'(c_x1) - DW'(c_x0);
    a_dy  <= DW'(c_y1) - DW'(c_y0);
    a_x0  <= c_x0;
    a_y0  <= c_y0;
    a_sz  <= c_sz;
    a_tag <= c_tag;
  end

  // box corners, clamped
  logic                 b_vld;
  logic signed [CW-1:0] b_minx, b_maxx, b_miny, b_maxy, b_x0, b_y0;
  logic signed [DW-1:0] b_dx, b_dy;
  logic [TAG_W-1:0]     b_tag;
  logic signed [BW-1:0] szx;

  assign szx = BW'($signed({1'b0, a_sz}));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_minx <= clamp_c(BW'(a_ox));
    b_maxx <= clamp_c(BW'(a_ox) + szx);
    b_miny <= clamp_c(BW'(a_oy));
    b_maxy <= clamp_c(BW'(a_oy) + szx);
    b_x0   <= a_x0;
    b_y0   <= a_y0;
    b_dx   <= a_dx;
    b_dy   <= a_dy;
    b_tag  <= a_tag;
  end

  // edge terms p and q, dividend and divisor magnitudes
  logic signed [DW-1:0] pv [4];
  logic signed [DW-1:0] qv [4];
  logic                 k_vld;
  logic [NW-1:0]        k_n [4];
  logic [DW-1:0]        k_d [4];
  side_t                k_side;

  assign pv[0] = -b_dx;
  assign qv[0] = DW'(b_x0) - DW'(b_minx);
  assign pv[1] = b_dx;
  assign qv[1] = DW'(b_maxx) - DW'(b_x0);
  assign pv[2] = -b_dy;
  assign qv[2] = DW'(b_y0) - DW'(b_miny);
  assign pv[3] = b_dy;
  assign qv[3] = DW'(b_maxy) - DW'(b_y0);

  always_ff @(posedge clk) begin
    if (rst) begin
      k_vld <= 1'b0;
    end else begin
      k_vld <= b_vld;
    end
    for (int i = 0; i < 4; i++) begin
      k_n[i]            <= (NW'(mag_d(qv[i])) << T_FRAC) + NW'(mag_d(pv[i]) >> 1);
      k_d[i]            <= mag_d(pv[i]);
      k_side.pneg[i]    <= pv[i][DW-1];
      k_side.pzero[i]   <= (pv[i] == '0);
      k_side.rneg[i]    <= pv[i][DW-1] ^ qv[i][DW-1];
    end
    k_side.zok <= ((pv[0] != '0) || !qv[0][DW-1]) && ((pv[1] != '0) || !qv[1][DW-1]) &&
                  ((pv[2] != '0) || !qv[2][DW-1]) && ((pv[3] != '0) || !qv[3][DW-1]);
    k_side.x0  <= b_x0;
    k_side.y0  <= b_y0;
    k_side.dx  <= b_dx;
    k_side.dy  <= b_dy;
    k_side.tag <= b_tag;
  end

  // restoring dividers: overflow check, then one quotient bit per stage
  logic              dv_vld  [DV_N];
  side_t             dv_side [DV_N];
  logic [NW-1:0]     dv_rem  [DV_N][4];
  logic [DW-1:0]     dv_den  [DV_N][4];
  logic [Q_BITS-1:0] dv_q    [DV_N][4];
  logic              dv_sat  [DV_N][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else begin
      dv_vld[0] <= k_vld;
    end
    dv_side[0] <= k_side;
    for (int i = 0; i < 4; i++) begin
      dv_sat[0][i] <= k_n[i] >= (NW'(k_d[i]) << Q_BITS);
      dv_rem[0][i] <= k_n[i];
      dv_den[0][i] <= k_d[i];
      dv_q[0][i]   <= '0;
    end
  end

  for (genvar j = 1; j < DV_N; j++) begin : g_div
    localparam int K = DV_N - 1 - j;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j] <= 1'b0;
      end else begin
        dv_vld[j] <= dv_vld[j-1];
      end
      dv_side[j] <= dv_side[j-1];
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [NW-1:0]     sub;
      logic              take;
      logic [Q_BITS-1:0] qn;

      assign sub  = NW'(dv_den[j-1][i]) << K;
      assign take = !dv_sat[j-1][i] && (dv_rem[j-1][i] >= sub);

      always_comb begin
        qn    = dv_q[j-1][i];
        qn[K] = take;
      end

      always_ff @(posedge clk) begin
        dv_rem[j][i] <= take ? dv_rem[j-1][i] - sub : dv_rem[j-1][i];
        dv_den[j][i] <= dv_den[j-1][i];
        dv_q[j][i]   <= qn;
        dv_sat[j][i] <= dv_sat[j-1][i];
      end
    end
  end

  // combine entry and exit parameters
  logic signed [Q_BITS:0] t0c, t1c;
  logic                   e_vld, e_ok;
  logic [T_FRAC:0]        e_t0, e_t1;
  side_t                  e_side;

  always_comb begin
    logic [Q_BITS-1:0]      rm;
    logic signed [Q_BITS:0] rr;
    t0c = '0;
    t1c = T_ONE;
    for (int i = 0; i < 4; i++) begin
      rm = (dv_sat[DV_N-1][i] || dv_q[DV_N-1][i] > R_SAT) ? R_SAT : dv_q[DV_N-1][i];
      rr = dv_side[DV_N-1].rneg[i] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
      if (!dv_side[DV_N-1].pzero[i]) begin
        if (dv_side[DV_N-1].pneg[i]) begin
          if (rr > t0c) t0c = rr;
        end else begin
          if (rr < t1c) t1c = rr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= dv_vld[DV_N-1];
    end
    e_ok   <= dv_side[DV_N-1].zok && (t0c <= t1c);
    e_t0   <= t0c[T_FRAC:0];
    e_t1   <= t1c[T_FRAC:0];
    e_side <= dv_side[DV_N-1];
  end

  // endpoint products
  logic                 f_vld, f_ok;
  logic signed [PW-1:0] f_sx, f_sy, f_ex, f_ey;
  logic signed [CW-1:0] f_x0, f_y0;
  logic [TAG_W-1:0]     f_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= e_vld;
    end
    f_sx  <= $signed({1'b0, e_t0}) * e_side.dx;
    f_sy  <= $signed({1'b0, e_t0}) * e_side.dy;
    f_ex  <= $signed({1'b0, e_t1}) * e_side.dx;
    f_ey  <= $signed({1'b0, e_t1}) * e_side.dy;
    f_ok  <= e_ok;
    f_x0  <= e_side.x0;
    f_y0  <= e_side.y0;
    f_tag <= e_side.tag;
  end

  // round and place
  logic                 g_vld, g_ok;
  logic signed [EW-1:0] g_sx, g_sy, g_ex, g_ey;
  logic [TAG_W-1:0]     g_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld <= 1'b0;
    end else begin
      g_vld <= f_vld;
    end
    g_sx  <= place(f_x0, f_sx);
    g_sy  <= place(f_y0, f_sy);
    g_ex  <= place(f_x0, f_ex);
    g_ey  <= place(f_y0, f_ey);
    g_ok  <= f_ok;
    g_tag <= f_tag;
  end

  // drop zero-length pieces
  logic keep;

  assign keep = g_ok && !((g_sx == g_ex) && (g_sy == g_ey));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= g_vld;
    end
    result.kept         <= keep;
    result.clip_start_x <= keep ? OUT_W'(g_sx) : '0;
    result.clip_start_y <= keep ? OUT_W'(g_sy) : '0;
    result.clip_end_x   <= keep ? OUT_W'(g_ex) : '0;
    result.clip_end_y   <= keep ? OUT_W'(g_ey) : '0;
    result.tag_out      <= g_tag;
  end

  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.kept |->
      result.clip_start_x == '0 && result.clip_start_y == '0 &&
      result.clip_end_x == '0 && result.clip_end_y == '0)
    else $error("rejected result carries nonzero coordinates");

  a_cfg_write : assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> tsize == $past(cfg_data))
    else $error("tile size write lost");

  a_entry_range : assert property (@(posedge clk) disable iff (rst)
    e_vld && e_ok |-> e_t0 <= e_t1 && e_t1 <= T_ONE[T_FRAC:0])
    else $error("clip parameters out of order");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the tile line clipper against an in-bench fixed-point Liang-Barsky
// predictor, through directed corner cases and bursts of random segments.
// ----------------------------------------------------------------------------
module tb_top;
  import tlc_pkg::*;

  localparam int LATENCY   = 35;
  localparam int WDOG_MAX  = 2000;
  localparam longint Q_ONE = 64'sd1 << 24;
  localparam longint R_MAX = 64'sd2 << 24;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  item_t             item = '0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TILE_W-1:0] cfg_data = '0;
  logic              result_valid;
  result_t           result;

  result_t     clip_queue[$];
  longint      tile_edge = 1;
  int          err_count = 0;
  int          idle_cycles = 0;

  tile_line_clipper DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    err_count++;
  endtask

  function automatic longint magn(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v < -64'sd2147483648) return -64'sd2147483648;
    if (v > 64'sd2147483647) return 64'sd2147483647;
    return v;
  endfunction

  // narrow the parameter window for one box edge; return 0 to drop
  function automatic bit edge_test(input longint p, input longint q,
                                   inout longint t0, inout longint t1);
    longint r;
    bit     neg;
    if (p == 0) return q >= 0;
    neg = (q < 0) != (p < 0);
    r = ((magn(q) << 24) + magn(p) / 2) / magn(p);
    if (r > R_MAX) r = R_MAX;
    if (neg) r = -r;
    if (p < 0) begin
      if (r > t1) return 0;
      if (r > t0) t0 = r;
      return 1;
    end
    if (r < t0) return 0;
    if (r < t1) t1 = r;
    return 1;
  endfunction

  function automatic longint point_at(input longint a0, input longint d, input longint t);
    longint prod, m;
    prod = t * d;
    m = (magn(prod) + 64'sd128) >>> 8;
    return (a0 <<< 16) + (prod < 0 ? -m : m);
  endfunction

  function automatic result_t clip_segment(input item_t it);
    result_t res;
    longint x0, y0, x1, y1, ox, oy, minx, maxx, miny, maxy, dx, dy, t0, t1;
    bit ok;
    x0 = it.start_x; y0 = it.start_y; x1 = it.end_x; y1 = it.end_y;
    ox = longint'(it.tile_col) * tile_edge;
    oy = longint'(it.tile_row) * tile_edge;
    minx = clamp32(ox); maxx = clamp32(ox + tile_edge);
    miny = clamp32(oy); maxy = clamp32(oy + tile_edge);
    dx = x1 - x0; dy = y1 - y0;
    t0 = 0; t1 = Q_ONE;
    res = '0;
    ok = edge_test(-dx, x0 - minx, t0, t1) && edge_test(dx, maxx - x0, t0, t1) &&
         edge_test(-dy, y0 - miny, t0, t1) && edge_test(dy, maxy - y0, t0, t1) &&
         t0 <= t1;
    if (ok) begin
      res.clip_start_x = point_at(x0, dx, t0);
      res.clip_start_y = point_at(y0, dy, t0);
      res.clip_end_x   = point_at(x0, dx, t1);
      res.clip_end_y   = point_at(y0, dy, t1);
      if (res.clip_start_x == res.clip_end_x && res.clip_start_y == res.clip_end_y)
        ok = 0;
    end
    if (!ok) res = '0;
    res.kept    = ok;
    res.tag_out = it.source_tag;
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (clip_queue.size() == 0) begin
        report("unexpected result", result.tag_out, 0);
      end else begin
        want = clip_queue.pop_front();
        if (result.kept !== want.kept) report("kept", result.kept, want.kept);
        if (result.clip_start_x !== want.clip_start_x)
          report("clip_start_x", result.clip_start_x, want.clip_start_x);
        if (result.clip_start_y !== want.clip_start_y)
          report("clip_start_y", result.clip_start_y, want.clip_start_y);
        if (result.clip_end_x !== want.clip_end_x)
          report("clip_end_x", result.clip_end_x, want.clip_end_x);
        if (result.clip_end_y !== want.clip_end_y)
          report("clip_end_y", result.clip_end_y, want.clip_end_y);
        if (result.tag_out !== want.tag_out) report("tag_out", result.tag_out, want.tag_out);
      end
    end
  end

  // watchdog: cycles with nothing accepted and no result
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // start stays high after the request; callers drop it before any gap
  task automatic send_item(input item_t it);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    clip_queue.push_back(clip_segment(it));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (clip_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tile_size(input logic [TILE_W-1:0] sz);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tile_edge = (sz == 0) ? 1 : longint'(sz);
  endtask

  function automatic item_t make_item(input int sx, sy, ex, ey, col, row);
    item_t it;
    it.start_x = sx; it.start_y = sy; it.end_x = ex; it.end_y = ey;
    it.tile_col = col; it.tile_row = row;
    it.source_tag = TAG_W'($urandom);
    return it;
  endfunction

  task automatic test_directed();
    write_tile_size(31'd16);
    send_item(make_item(2, 3, 10, 12, 0, 0));         // fully inside
    send_item(make_item(-5, 8, 30, 8, 0, 0));         // horizontal, crossing both sides
    send_item(make_item(8, -5, 8, 30, 0, 0));         // vertical
    send_item(make_item(-5, 20, 30, 20, 0, 0));       // parallel and outside
    send_item(make_item(4, 4, 4, 4, 0, 0));           // zero length
    send_item(make_item(-10, -10, 40, 40, 0, 0));     // diagonal through corners
    send_item(make_item(20, 0, 30, 40, 0, 0));        // misses the box
    send_item(make_item(16, 0, 16, 16, 0, 0));        // on the edge
    send_item(make_item(0, 0, 3, 7, -1, -1));         // touches a corner only
    send_item(make_item(-100, -50, 100, 60, 1, -2));
    write_tile_size(31'd0);                           // zero size acts as one
    send_item(make_item(0, 0, 1, 1, 0, 0));
    send_item(make_item(-3, 1, 5, 0, 0, 0));
    write_tile_size(31'h7FFFFFFF);                    // corners saturate
    send_item(make_item(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0));
    send_item(make_item(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, -1, -1));
    send_item(make_item(32'h80000000, 0, 32'h7FFFFFFF, 5, 32'h7FFFFFFF, 32'h80000000));
    send_item(make_item(0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1));
    send_item(make_item(-7, 3, 99, 2, 32'h80000000, 32'h7FFFFFFF));
    write_tile_size(31'd1);
    send_item(make_item(0, 0, 1, 1, 0, 0));
    send_item(make_item(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0));
  endtask

  task automatic test_random(input int count);
    item_t it;
    int    sent, burst, sz, span;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        sz = int'(tile_edge);
        span = (sz > 100000) ? 100000 : sz;
        it.source_tag = TAG_W'($urandom);
        it.tile_col = $signed($urandom_range(0, 20)) - 10;
        it.tile_row = $signed($urandom_range(0, 20)) - 10;
        // mostly segments near the chosen tile, some full-range noise
        if ($urandom_range(0, 9) < 8) begin
          it.start_x = it.tile_col * sz + $signed($urandom_range(0, 4 * span)) - 2 * span;
          it.start_y = it.tile_row * sz + $signed($urandom_range(0, 4 * span)) - 2 * span;
          it.end_x   = it.tile_col * sz + $signed($urandom_range(0, 4 * span)) - 2 * span;
          it.end_y   = it.tile_row * sz + $signed($urandom_range(0, 4 * span)) - 2 * span;
        end else begin
          it.start_x = $urandom; it.start_y = $urandom;
          it.end_x = $urandom; it.end_y = $urandom;
          if ($urandom_range(0, 1)) begin
            it.tile_col = $urandom; it.tile_row = $urandom;
          end
        end
        send_item(it);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_tile_size(31'd5);
    test_random(350);
    drain();   // hold until every pending request has answered
    write_tile_size(31'd1000);
    test_random(350);
    write_tile_size(31'd2);
    test_random(350);
    write_tile_size(TILE_W'($urandom_range(1, 31'h7FFFFFFF)));
    test_random(350);
    drain();
    repeat (LATENCY + 5) @(posedge clk);
    if (err_count == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
